// ----- hw/rtl/chained_hash_map_defines.svh -----
// ----------------------------------------------------------------------------
// chained_hash_map_defines.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_DEFINES_SVH
`define CHAINED_HASH_MAP_DEFINES_SVH

// same-cycle implication
`define CHM_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("chm check failed");

// next-cycle implication
`define CHM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("chm check failed");

`endif

// ----- hw/rtl/chm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared codes, constants and types of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam logic [1:0] OP_ENTER  = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam int CFG_BITS = 7;
   localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 7'd64;

   // dividend bits consumed per divider step
   localparam int DIGIT_BITS = 4;

   // entry store command
   typedef struct packed {
      logic rd;        // read key, value, next at rd address
      logic fill;      // write key, value, next at wr address
      logic set_val;   // write value only
      logic set_next;  // write next only
   } ent_cmd_type;

endpackage

// ----- hw/rtl/chained_hash_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map
// Key to value map with separate chaining over a pooled entry store.
// ----------------------------------------------------------------------------
// Usage
//  - Request: drive req_op, req_key, req_value_in and raise start; the beat is
//    taken on a clock edge where start is high and busy is low.
//  - Result: one beat per request on rsp_existed, rsp_value_out, rsp_pool_full,
//    marked by rsp_strobe for exactly one cycle. The receiver cannot stall;
//    the beat is gone after that cycle.
//  - Config: bucket_count is written through csr_valid/csr_ready/csr_data,
//    only while busy is low.
//  - Sequence: clear goes straight to the action state. Enter, find and
//    remove run the remainder unit, read the bucket head, read one chain
//    entry per entry visited, then act and write back. The chain walk
//    through the entry memory, one read per entry, and the remainder unit
//    set the time taken. One request at a time.
//  - The next request may start in the cycle the result is shown.
//  - Reset: all buckets empty, free list empty, pool unused, bucket_count 64.
//    No clearing pass; bucket validity lives in flops.
// ----------------------------------------------------------------------------
module chained_hash_map
   import chm_pkg::*;
#(
   parameter int MAX_BUCKETS  = 64,
   parameter int POOL_ENTRIES = 256,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [31:0]         req_key,
   input  logic [31:0]         req_value_in,
   // result channel
   output logic                rsp_strobe,
   output logic                rsp_existed,
   output logic [31:0]         rsp_value_out,
   output logic                rsp_pool_full,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CFG_BITS-1:0] csr_data
);

   // stored key/value widths: fields are 32 bits on the ports
   localparam int KW     = (KEY_BITS < 32) ? KEY_BITS : 32;
   localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int ADDR_W = $clog2(POOL_ENTRIES);
   localparam int REM_W  = $clog2(MAX_BUCKETS + 1);
   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam logic [LINK_W-1:0] NullLink = LINK_W'(POOL_ENTRIES);

   // sequencer states
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIV    = 4'd1;
   localparam logic [3:0] ST_HEAD   = 4'd2;
   localparam logic [3:0] ST_WALK   = 4'd3;
   localparam logic [3:0] ST_ACT    = 4'd4;
   localparam logic [3:0] ST_UNLINK = 4'd5;
   localparam logic [3:0] ST_POP    = 4'd6;
   localparam logic [3:0] ST_FILL   = 4'd7;
   localparam logic [3:0] ST_LINK   = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CFG_BITS-1:0] cfg_ff;

   // request registers
   logic [1:0]          op_ff, op_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [VW-1:0]       val_ff, val_in;

   // walk registers
   logic [BKT_W-1:0]    bkt_ff, bkt_in;
   logic [LINK_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]   prev_ff, prev_in;
   logic [LINK_W-1:0]   nxt_ff, nxt_in;
   logic [LINK_W-1:0]   idx_ff, idx_in;
   logic [VW-1:0]       hit_val_ff, hit_val_in;
   logic                found_ff, found_in;

   // pool allocator
   logic [LINK_W-1:0]   free_ff, free_in;
   logic [LINK_W-1:0]   fresh_ff, fresh_in;

   // bucket heads: memory plus a valid flop per bucket
   logic [LINK_W-1:0]      head_mem [MAX_BUCKETS];
   logic [LINK_W-1:0]      head_rd_ff;
   logic [MAX_BUCKETS-1:0] head_vld_ff, head_vld_in;
   logic                   head_we;
   logic [LINK_W-1:0]      head_wdata;

   // result beat
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic                rsp_existed_ff, rsp_existed_in;
   logic [VW-1:0]       rsp_value_ff, rsp_value_in;
   logic                rsp_full_ff, rsp_full_in;

   // divider
   logic                div_start;
   logic                div_done;
   logic [REM_W-1:0]    div_rem;
   logic [REM_W-1:0]    nb;
   logic [31:0]         nb_wide;

   // entry store
   ent_cmd_type         ent_cmd;
   logic [ADDR_W-1:0]   ent_rd_addr;
   logic [ADDR_W-1:0]   ent_wr_addr;
   logic [LINK_W-1:0]   ent_wr_next;
   logic [KW-1:0]       ent_rd_key;
   logic [VW-1:0]       ent_rd_val;
   logic [LINK_W-1:0]   ent_rd_next;

   logic                accept;
   logic [LINK_W-1:0]   head_ptr;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // bucket count out of range: zero acts as one, above maximum clamps
   always_comb begin
      if (cfg_ff == '0) begin
         nb_wide = 32'd1;
      end else if (32'(cfg_ff) > 32'(MAX_BUCKETS)) begin
         nb_wide = 32'(MAX_BUCKETS);
      end else begin
         nb_wide = 32'(cfg_ff);
      end
   end
   assign nb = nb_wide[REM_W-1:0];

   assign div_start = accept && (req_op != OP_CLEAR);

   chm_divider #(
      .KEY_W (KW),
      .REM_W (REM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_key[KW-1:0]),
      .divisor   (nb),
      .done      (div_done),
      .remainder (div_rem)
   );

   chm_entry_mem #(
      .ENTRIES (POOL_ENTRIES),
      .KEY_W   (KW),
      .VAL_W   (VW),
      .LINK_W  (LINK_W),
      .ADDR_W  (ADDR_W)
   ) u_entry_mem (
      .clock   (clock),
      .cmd     (ent_cmd),
      .rd_addr (ent_rd_addr),
      .wr_addr (ent_wr_addr),
      .wr_key  (key_ff),
      .wr_val  (val_ff),
      .wr_next (ent_wr_next),
      .rd_key  (ent_rd_key),
      .rd_val  (ent_rd_val),
      .rd_next (ent_rd_next)
   );

   // an invalid bucket reads as an empty chain
   assign head_ptr = head_vld_ff[bkt_ff] ? head_rd_ff : NullLink;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      bkt_in         = bkt_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      nxt_in         = nxt_ff;
      idx_in         = idx_ff;
      hit_val_in     = hit_val_ff;
      found_in       = found_ff;
      free_in        = free_ff;
      fresh_in       = fresh_ff;
      head_vld_in    = head_vld_ff;
      head_we        = 1'b0;
      head_wdata     = nxt_ff;
      rsp_strobe_in  = 1'b0;
      rsp_existed_in = 1'b0;
      rsp_value_in   = '0;
      rsp_full_in    = 1'b0;
      ent_cmd        = '0;
      ent_rd_addr    = cur_ff[ADDR_W-1:0];
      ent_wr_addr    = cur_ff[ADDR_W-1:0];
      ent_wr_next    = nxt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               key_in   = req_key[KW-1:0];
               val_in   = req_value_in[VW-1:0];
               state_in = (req_op == OP_CLEAR) ? ST_ACT : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               bkt_in   = div_rem[BKT_W-1:0];
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            prev_in  = NullLink;
            cur_in   = head_ptr;
            found_in = 1'b0;
            if (head_ptr == NullLink) begin
               state_in = ST_ACT;
            end else begin
               ent_cmd.rd  = 1'b1;
               ent_rd_addr = head_ptr[ADDR_W-1:0];
               state_in    = ST_WALK;
            end
         end
         ST_WALK: begin
            if (ent_rd_key == key_ff) begin
               found_in   = 1'b1;
               nxt_in     = ent_rd_next;
               hit_val_in = ent_rd_val;
               state_in   = ST_ACT;
            end else begin
               prev_in = cur_ff;
               cur_in  = ent_rd_next;
               if (ent_rd_next == NullLink) begin
                  state_in = ST_ACT;
               end else begin
                  ent_cmd.rd  = 1'b1;
                  ent_rd_addr = ent_rd_next[ADDR_W-1:0];
               end
            end
         end
         ST_ACT: begin
            state_in = ST_IDLE;
            case (op_ff)
               OP_CLEAR: begin
                  head_vld_in   = '0;
                  free_in       = NullLink;
                  fresh_in      = '0;
                  rsp_strobe_in = 1'b1;
               end
               OP_FIND: begin
                  rsp_strobe_in  = 1'b1;
                  rsp_existed_in = found_ff;
                  rsp_value_in   = found_ff ? hit_val_ff : '0;
               end
               OP_REMOVE: begin
                  if (found_ff) begin
                     if (prev_ff == NullLink) begin
                        head_we    = 1'b1;
                        head_wdata = nxt_ff;
                     end else begin
                        ent_cmd.set_next = 1'b1;
                        ent_wr_addr      = prev_ff[ADDR_W-1:0];
                        ent_wr_next      = nxt_ff;
                     end
                     state_in = ST_UNLINK;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end
               default: begin
                  // enter
                  if (found_ff) begin
                     ent_cmd.set_val = 1'b1;
                     ent_wr_addr     = cur_ff[ADDR_W-1:0];
                     rsp_strobe_in   = 1'b1;
                     rsp_existed_in  = 1'b1;
                  end else if (free_ff != NullLink) begin
                     ent_cmd.rd  = 1'b1;
                     ent_rd_addr = free_ff[ADDR_W-1:0];
                     state_in    = ST_POP;
                  end else if (fresh_ff != NullLink) begin
                     idx_in   = fresh_ff;
                     fresh_in = fresh_ff + 1'b1;
                     state_in = ST_FILL;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_full_in   = 1'b1;
                  end
               end
            endcase
         end
         ST_UNLINK: begin
            // freed entry goes to the head of the free list
            ent_cmd.set_next = 1'b1;
            ent_wr_addr      = cur_ff[ADDR_W-1:0];
            ent_wr_next      = free_ff;
            free_in          = cur_ff;
            rsp_strobe_in    = 1'b1;
            rsp_existed_in   = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_POP: begin
            idx_in   = free_ff;
            free_in  = ent_rd_next;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            ent_cmd.fill = 1'b1;
            ent_wr_addr  = idx_ff[ADDR_W-1:0];
            ent_wr_next  = NullLink;
            state_in     = ST_LINK;
         end
         ST_LINK: begin
            // append at the tail
            if (prev_ff == NullLink) begin
               head_we             = 1'b1;
               head_wdata          = idx_ff;
               head_vld_in[bkt_ff] = 1'b1;
            end else begin
               ent_cmd.set_next = 1'b1;
               ent_wr_addr      = prev_ff[ADDR_W-1:0];
               ent_wr_next      = idx_ff;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // bucket head memory; read address follows the divider remainder
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bkt_ff] <= head_wdata;
      end
      head_rd_ff <= head_mem[div_rem[BKT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cfg_ff        <= BUCKET_COUNT_RESET;
         free_ff       <= NullLink;
         fresh_ff      <= '0;
         head_vld_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_ff       <= free_in;
         fresh_ff      <= fresh_in;
         head_vld_ff   <= head_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      bkt_ff         <= bkt_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      nxt_ff         <= nxt_in;
      idx_ff         <= idx_in;
      hit_val_ff     <= hit_val_in;
      found_ff       <= found_in;
      rsp_existed_ff <= rsp_existed_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_existed   = rsp_existed_ff;
   assign rsp_value_out = 32'(rsp_value_ff);
   assign rsp_pool_full = rsp_full_ff;

endmodule

// ----- hw/rtl/chm_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_divider
// Iterative remainder unit, DIGIT_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module chm_divider
   import chm_pkg::*;
#(
   parameter int KEY_W = 32,
   parameter int REM_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [KEY_W-1:0] dividend,
   input  logic [REM_W-1:0] divisor,
   output logic             done,
   output logic [REM_W-1:0] remainder
);

   localparam int Steps = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PadW  = Steps * DIGIT_BITS;
   localparam int CntW  = $clog2(Steps + 1);

   logic [PadW-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   always_comb begin
      logic [REM_W:0] part;
      part    = {1'b0, rem_ff};
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         part = {part[REM_W-1:0], quo_ff[PadW-1-i]};
         if (part >= {1'b0, divisor}) begin
            part = part - {1'b0, divisor};
         end
      end
      rem_in = rem_ff;
      if (start) begin
         quo_in = PadW'(dividend);
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = quo_ff << DIGIT_BITS;
         rem_in = part[REM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(Steps - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- hw/rtl/chm_entry_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_entry_mem
// Entry pool store: key, value and next link, one read and one write port.
// ----------------------------------------------------------------------------
module chm_entry_mem
   import chm_pkg::*;
#(
   parameter int ENTRIES = 256,
   parameter int KEY_W   = 32,
   parameter int VAL_W   = 32,
   parameter int LINK_W  = 9,
   parameter int ADDR_W  = 8
) (
   input  logic              clock,
   input  ent_cmd_type       cmd,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [KEY_W-1:0]  wr_key,
   input  logic [VAL_W-1:0]  wr_val,
   input  logic [LINK_W-1:0] wr_next,
   output logic [KEY_W-1:0]  rd_key,
   output logic [VAL_W-1:0]  rd_val,
   output logic [LINK_W-1:0] rd_next
);

   logic [KEY_W-1:0]  key_mem  [ENTRIES];
   logic [VAL_W-1:0]  val_mem  [ENTRIES];
   logic [LINK_W-1:0] next_mem [ENTRIES];

   logic [KEY_W-1:0]  rd_key_ff;
   logic [VAL_W-1:0]  rd_val_ff;
   logic [LINK_W-1:0] rd_next_ff;

   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (cmd.fill || cmd.set_val) begin
         val_mem[wr_addr] <= wr_val;
      end
      if (cmd.fill || cmd.set_next) begin
         next_mem[wr_addr] <= wr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_val_ff  <= val_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
      end
   end

   assign rd_key  = rd_key_ff;
   assign rd_val  = rd_val_ff;
   assign rd_next = rd_next_ff;

endmodule

// ----- hw/rtl/chm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks of the chained hash map, bound to the top level.
// ----------------------------------------------------------------------------
`include "chained_hash_map_defines.svh"

module chm_checker
   import chm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_existed,
   input logic [31:0] rsp_value_out,
   input logic        rsp_pool_full,
   input logic        csr_valid,
   input logic        csr_ready
);

   // a taken request keeps the block busy
   `CHM_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // the block goes idle only with a result beat
   `CHM_ASSERT_NOW(a_idle_beat, clock, reset, $fell(busy), rsp_strobe)

   // a result beat never overlaps work in progress
   `CHM_ASSERT_NOW(a_beat_idle, clock, reset, rsp_strobe, !busy)

   // a full pool reports nothing stored and no value
   `CHM_ASSERT_NOW(a_full_clean, clock, reset, rsp_strobe && rsp_pool_full,
      !rsp_existed && (rsp_value_out == 32'd0))

   // config is never taken mid-request
   `CHM_ASSERT_NOW(a_cfg_idle, clock, reset, csr_valid && csr_ready, !busy)

endmodule

bind chained_hash_map chm_checker u_chm_checker (.*);
